### rtl/core/i2cm_pkg.sv
// Package with the command codes, result type and constants of the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_e_t;

    localparam int unsigned SLOT_TICKS_W = 10;
    localparam int unsigned SLOT_IDX_W   = 5;

    localparam logic [SLOT_TICKS_W-1:0] SLOT_TICKS_RESET = 10'd6;

    localparam logic [SLOT_IDX_W-1:0] LAST_SLOT_START = 5'd3;
    localparam logic [SLOT_IDX_W-1:0] LAST_SLOT_STOP  = 5'd2;
    localparam logic [SLOT_IDX_W-1:0] LAST_SLOT_BYTE  = 5'd20;

    localparam logic [SLOT_IDX_W-1:0] SLOT_WR_LAST_BIT = 5'd16;
    localparam logic [SLOT_IDX_W-1:0] SLOT_WR_ACK      = 5'd18;
    localparam logic [SLOT_IDX_W-1:0] SLOT_WR_ACK_HOLD = 5'd19;
    localparam logic [SLOT_IDX_W-1:0] SLOT_RD_FIRST    = 5'd1;
    localparam logic [SLOT_IDX_W-1:0] SLOT_RD_SAMPLE0  = 5'd2;
    localparam logic [SLOT_IDX_W-1:0] SLOT_RD_LAST     = 5'd16;
    localparam logic [SLOT_IDX_W-1:0] SLOT_RD_NACK     = 5'd19;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_released;
        logic       busy_res;
        logic       done_res;
        logic       nack_seen;
        logic [7:0] rx_byte;
        logic       dropped;
    } result_t;

endpackage

### rtl/core/i2cm_tick_if.sv
// Interface carrying tick requests (with optional command) into the engine.
`timescale 1ns / 1ps

interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, output command, output tx_byte, output sda_in, input ready);
    modport sink   (input valid, input command, input tx_byte, input sda_in, output ready);
endinterface

### rtl/core/i2cm_res_if.sv
// Interface carrying per-tick bus results out of the engine.
`timescale 1ns / 1ps

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] rx_byte;
    logic       dropped;

    modport source (output valid, output scl_level, output sda_level, output sda_released,
                    output busy_res, output done_res, output nack_seen, output rx_byte,
                    output dropped, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input sda_released,
                    input busy_res, input done_res, input nack_seen, input rx_byte,
                    input dropped, output ready);
endinterface

### rtl/core/i2cm_cfg_if.sv
// Interface carrying writes of the slot length register.
`timescale 1ns / 1ps

interface i2cm_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] slot_ticks;

    modport source (output valid, output slot_ticks, input ready);
    modport sink   (input valid, input slot_ticks, output ready);
endinterface

### rtl/core/i2cm_seq.sv
// Bus slot sequencer: holds the command state and forms the result of each tick.
`timescale 1ns / 1ps

module i2cm_seq
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [2:0]                        command,
    input  logic [7:0]                        tx_byte,
    input  logic                              sda_in,
    input  logic [i2cm_pkg::SLOT_TICKS_W-1:0] slot_ticks,
    output i2cm_pkg::result_t                 result
);

    typedef struct packed {
        logic scl;
        logic sda;
        logic rel;
    } levels_t;

    i2cm_pkg::cmd_e_t                   active_reg, active_next;
    logic [i2cm_pkg::SLOT_IDX_W-1:0]    slot_reg, slot_next;
    logic [i2cm_pkg::SLOT_TICKS_W-1:0]  tick_reg, tick_next;
    logic [7:0]                         shift_reg, shift_next;
    logic                               scl_line_reg, scl_line_next;
    logic                               sda_line_reg, sda_line_next;
    logic                               nack_reg, nack_next;
    logic [7:0]                         rx_reg, rx_next;

    i2cm_pkg::cmd_e_t                   cmd_in;
    i2cm_pkg::cmd_e_t                   cur_cmd;
    logic [i2cm_pkg::SLOT_IDX_W-1:0]    cur_slot;
    logic [i2cm_pkg::SLOT_TICKS_W-1:0]  cur_tick;
    logic [7:0]                         cur_shift;
    logic                               cmd_known;
    logic                               idle;
    logic                               start_new;
    logic                               running;
    logic [i2cm_pkg::SLOT_TICKS_W-1:0]  len_ticks;
    logic                               slot_end;
    logic                               last_slot;
    levels_t                            lv;

    function automatic levels_t slot_levels(i2cm_pkg::cmd_e_t cmd,
                                            logic [i2cm_pkg::SLOT_IDX_W-1:0] s,
                                            logic [7:0] data);
        levels_t l;
        l = '{scl: 1'b0, sda: 1'b1, rel: 1'b0};
        case (cmd)
            i2cm_pkg::CMD_START:
            begin
                l.scl = (s < i2cm_pkg::LAST_SLOT_START);
                l.sda = (s == '0);
            end
            i2cm_pkg::CMD_STOP:
            begin
                l.scl = (s != '0);
                l.sda = (s == i2cm_pkg::LAST_SLOT_STOP);
            end
            i2cm_pkg::CMD_WRITE:
            begin
                if (s < i2cm_pkg::SLOT_WR_LAST_BIT)
                begin
                    // Bit index is 7 minus the bit number, i.e. its inverse.
                    l.scl = s[0];
                    l.sda = data[~s[3:1]];
                end
                else if (s == i2cm_pkg::SLOT_WR_LAST_BIT)
                begin
                    l.sda = data[0];
                end
                else if (s == i2cm_pkg::SLOT_WR_ACK || s == i2cm_pkg::SLOT_WR_ACK_HOLD)
                begin
                    l.scl = 1'b1;
                    l.rel = 1'b1;
                end
            end
            i2cm_pkg::CMD_READ:
            begin
                if (s >= i2cm_pkg::SLOT_RD_FIRST && s <= i2cm_pkg::SLOT_RD_LAST)
                begin
                    l.scl = ~s[0];
                    l.rel = 1'b1;
                end
                else if (s == i2cm_pkg::SLOT_RD_NACK)
                begin
                    l.scl = 1'b1;
                end
            end
            default:
            begin
                l = '{scl: 1'b0, sda: 1'b1, rel: 1'b0};
            end
        endcase
        return l;
    endfunction

    always_comb
    begin
        cmd_in    = i2cm_pkg::cmd_e_t'(command);
        cmd_known = (cmd_in == i2cm_pkg::CMD_START) || (cmd_in == i2cm_pkg::CMD_STOP) ||
                    (cmd_in == i2cm_pkg::CMD_WRITE) || (cmd_in == i2cm_pkg::CMD_READ);
        idle      = (active_reg == i2cm_pkg::CMD_NONE);
        start_new = idle && cmd_known;

        cur_cmd   = start_new ? cmd_in : active_reg;
        cur_slot  = start_new ? '0 : slot_reg;
        cur_tick  = start_new ? '0 : tick_reg;
        cur_shift = start_new ? ((cmd_in == i2cm_pkg::CMD_WRITE) ? tx_byte : 8'h00) : shift_reg;
        running   = (cur_cmd != i2cm_pkg::CMD_NONE);

        lv        = slot_levels(cur_cmd, cur_slot, cur_shift);
        // A zero slot length behaves as one tick.
        len_ticks = (slot_ticks == '0) ? {{(i2cm_pkg::SLOT_TICKS_W-1){1'b0}}, 1'b1} : slot_ticks;
        slot_end  = ({1'b0, cur_tick} + {{i2cm_pkg::SLOT_TICKS_W{1'b0}}, 1'b1})
                    >= {1'b0, len_ticks};
        case (cur_cmd)
            i2cm_pkg::CMD_START: last_slot = (cur_slot >= i2cm_pkg::LAST_SLOT_START);
            i2cm_pkg::CMD_STOP:  last_slot = (cur_slot >= i2cm_pkg::LAST_SLOT_STOP);
            default:             last_slot = (cur_slot >= i2cm_pkg::LAST_SLOT_BYTE);
        endcase
    end

    always_comb
    begin
        active_next   = cur_cmd;
        slot_next     = cur_slot;
        tick_next     = cur_tick;
        shift_next    = cur_shift;
        scl_line_next = scl_line_reg;
        sda_line_next = sda_line_reg;
        nack_next     = nack_reg;
        rx_next       = rx_reg;
        if (running)
        begin
            scl_line_next = lv.scl;
            sda_line_next = lv.sda;
            if (slot_end)
            begin
                if (cur_cmd == i2cm_pkg::CMD_WRITE && cur_slot == i2cm_pkg::SLOT_WR_ACK)
                begin
                    nack_next = sda_in;
                end
                if (cur_cmd == i2cm_pkg::CMD_READ && cur_slot >= i2cm_pkg::SLOT_RD_SAMPLE0 &&
                    cur_slot <= i2cm_pkg::SLOT_RD_LAST && !cur_slot[0])
                begin
                    shift_next = {cur_shift[6:0], sda_in};
                end
                if (last_slot)
                begin
                    if (cur_cmd == i2cm_pkg::CMD_READ)
                    begin
                        rx_next = shift_next;
                    end
                    active_next = i2cm_pkg::CMD_NONE;
                    slot_next   = '0;
                end
                else
                begin
                    slot_next = cur_slot + 1'b1;
                end
                tick_next = '0;
            end
            else
            begin
                tick_next = cur_tick + 1'b1;
            end
        end
    end

    always_comb
    begin
        result.scl_level    = scl_line_next;
        result.sda_level    = sda_line_next;
        result.sda_released = running & lv.rel;
        result.busy_res     = running;
        result.done_res     = running & slot_end & last_slot;
        result.nack_seen    = nack_next;
        result.rx_byte      = rx_next;
        result.dropped      = !idle && cmd_known;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= i2cm_pkg::CMD_NONE;
            slot_reg     <= '0;
            tick_reg     <= '0;
            shift_reg    <= '0;
            scl_line_reg <= 1'b1;
            sda_line_reg <= 1'b1;
            nack_reg     <= 1'b1;
            rx_reg       <= '0;
        end
        else if (accept)
        begin
            active_reg   <= active_next;
            slot_reg     <= slot_next;
            tick_reg     <= tick_next;
            shift_reg    <= shift_next;
            scl_line_reg <= scl_line_next;
            sda_line_reg <= sda_line_next;
            nack_reg     <= nack_next;
            rx_reg       <= rx_next;
        end
    end

endmodule

### rtl/core/i2cm_skid.sv
// Two-entry output buffer that registers results and absorbs downstream stalls.
`timescale 1ns / 1ps

module i2cm_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  i2cm_pkg::result_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output i2cm_pkg::result_t pop_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    i2cm_pkg::result_t main_reg, main_next;
    i2cm_pkg::result_t skid_reg, skid_next;
    logic              push;
    logic              pop;

    always_comb
    begin
        push_ready      = !skid_valid_reg;
        push            = push_valid && !skid_valid_reg;
        pop             = main_valid_reg && pop_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            // Main stage is free: refill it, oldest request first.
            main_next       = skid_valid_reg ? skid_reg : push_data;
            main_valid_next = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign pop_valid = main_valid_reg;
    assign pop_data  = main_reg;

endmodule

### rtl/core/i2c_master_byte_engine_unit.sv
// Top level of the I2C master byte engine: tick input, result output and slot length register.
`timescale 1ns / 1ps

// The engine is a tick-driven I2C master sequencer. Every request on the tick channel is one
// bus time tick and may carry a command (start, stop, write byte or read byte); every request
// produces exactly one result request describing the SCL and SDA levels for that tick, the
// busy and done flags, the last acknowledge and read byte, and whether a command was dropped
// because another was still running. A command occupies a fixed number of half-bit slots, each
// lasting slot_ticks ticks (a value of zero acts as one). One tick is accepted in every clock
// cycle while the output buffer has room: the whole slot step is a single pass of logic from
// the incoming request and the sequencer state into a result register of that buffer, from
// which it is offered. The result side has a two-entry buffer, so a tick is still taken
// while one finished result waits; the tick channel stalls only when both entries are full.
// The slot length register is written through the configuration channel, which is always ready,
// and should only be changed while no command is in progress.
module i2c_master_byte_engine_unit
(
    input  logic              clk,
    input  logic              rst_n,
    i2cm_tick_if.sink         tick,
    i2cm_res_if.source        res,
    i2cm_cfg_if.sink          cfg
);

    logic [i2cm_pkg::SLOT_TICKS_W-1:0] slot_ticks_reg;
    logic                              tick_ready;
    logic                              tick_accept;
    i2cm_pkg::result_t                 step_result;
    i2cm_pkg::result_t                 out_result;

    // The configuration register takes every write at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ticks_reg <= i2cm_pkg::SLOT_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            slot_ticks_reg <= cfg.slot_ticks;
        end
    end

    // A tick request is accepted whenever the output buffer has room for its result.
    assign tick.ready  = tick_ready;
    assign tick_accept = tick.valid && tick_ready;

    i2cm_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (tick_accept),
        .command    (tick.command),
        .tx_byte    (tick.tx_byte),
        .sda_in     (tick.sda_in),
        .slot_ticks (slot_ticks_reg),
        .result     (step_result)
    );

    i2cm_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (tick.valid),
        .push_ready (tick_ready),
        .push_data  (step_result),
        .pop_valid  (res.valid),
        .pop_ready  (res.ready),
        .pop_data   (out_result)
    );

    assign res.scl_level    = out_result.scl_level;
    assign res.sda_level    = out_result.sda_level;
    assign res.sda_released = out_result.sda_released;
    assign res.busy_res     = out_result.busy_res;
    assign res.done_res     = out_result.done_res;
    assign res.nack_seen    = out_result.nack_seen;
    assign res.rx_byte      = out_result.rx_byte;
    assign res.dropped      = out_result.dropped;

endmodule

### rtl/core/i2cm_checker.sv
// Port-level checks of the I2C master byte engine, attached to the top level by bind.
`timescale 1ns / 1ps

module i2cm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       tick_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       scl_level,
    input logic       sda_level,
    input logic       sda_released,
    input logic       busy_res,
    input logic       done_res,
    input logic       dropped,
    input logic [7:0] rx_byte
);

    // A completing tick is always part of a running command.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!done_res || busy_res))
        else $error("done without busy");

    // A released SDA line reads as high and only happens while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && sda_released) |-> (sda_level && busy_res))
        else $error("released SDA not high or not busy");

    // Only a busy engine can drop a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && dropped) |-> busy_res)
        else $error("drop while idle");

    // Back-pressure on ticks only occurs with a result already waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !tick_ready |-> res_valid)
        else $error("tick stalled with no pending result");

    // A stalled result request holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(scl_level) &&
                                       $stable(sda_level) && $stable(rx_byte)))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_ready   (tick.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .scl_level    (res.scl_level),
    .sda_level    (res.sda_level),
    .sda_released (res.sda_released),
    .busy_res     (res.busy_res),
    .done_res     (res.done_res),
    .dropped      (res.dropped),
    .rx_byte      (res.rx_byte)
);
